@@ src/assert_macros.svh @@
// Assertion helpers used by the parser RTL (sld_parser.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define SLD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SLD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SLD_ASSERT(lbl, clk, rst, prop, msg)
`define SLD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/sld_pkg.sv @@
`default_nettype none

package sld_pkg;

  // Frame markers
  localparam logic [7:0] SYNC_LEAD  = 8'hFF;
  localparam logic [7:0] SYNC_MARK  = 8'h55;
  localparam logic [7:0] LEN_EXTEND = 8'h00;

  // Bytes counted by the length field ahead of the payload
  localparam logic [15:0] HDR_BYTES = 16'd4;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [3:0] {
    PH_SYNC1  = 4'd0,
    PH_SYNC2  = 4'd1,
    PH_LEN    = 4'd2,
    PH_LEN_LO = 4'd3,
    PH_LEN_HI = 4'd4,
    PH_ID     = 4'd5,
    PH_CMD    = 4'd6,
    PH_TR_LO  = 4'd7,
    PH_TR_HI  = 4'd8,
    PH_DATA   = 4'd9,
    PH_SUM    = 4'd10
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  command_code;
    logic [15:0] transaction_id;
    logic [15:0] frame_length;
    logic        checksum_ok;
  } res_t;

endpackage

`default_nettype wire

@@ src/sld_if.sv @@
`default_nettype none

// Received byte channel
interface sld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Lingo id configuration write channel
interface sld_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] accepted_lingo_id;
  modport source (output valid, output accepted_lingo_id, input ready);
  modport sink (input valid, input accepted_lingo_id, output ready);
endinterface

// Result channel
interface sld_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  command_code;
  logic [15:0] transaction_id;
  logic [15:0] frame_length;
  logic        checksum_ok;
  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output command_code, output transaction_id, output frame_length,
                  output checksum_ok, input ready);
  modport sink (input valid, input kind, input payload_byte, input payload_index,
                input command_code, input transaction_id, input frame_length,
                input checksum_ok, output ready);
endinterface

`default_nettype wire

@@ src/sld_parser.sv @@
`default_nettype none
`include "assert_macros.svh"

module sld_parser (
  input  wire logic      clk,
  input  wire logic      rst,
  sld_rx_if.sink         rx,
  sld_cfg_if.sink        cfg,
  input  wire logic      down_ready,
  output logic           res_valid,
  output sld_pkg::res_t  res
);

  sld_pkg::phase_t phase, phase_next;
  logic [7:0]  match_id;
  logic [15:0] length_value, length_value_next;
  logic [15:0] data_count, data_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  command_value, command_value_next;
  logic [15:0] transaction_value, transaction_value_next;

  logic        take;
  logic [7:0]  b;
  logic [7:0]  sum_add;
  logic [15:0] payload_len;
  logic [15:0] count_inc;
  logic        at_data;
  logic        at_sum;

  assign rx.ready  = down_ready;
  assign cfg.ready = 1'b1;
  assign take      = rx.valid && down_ready;
  assign b         = rx.rx_byte;
  assign sum_add   = running_sum + b;
  assign count_inc = data_count + 16'd1;
  assign payload_len = (length_value > sld_pkg::HDR_BYTES) ?
                       (length_value - sld_pkg::HDR_BYTES) : 16'd0;
  assign at_data   = (phase == sld_pkg::PH_DATA);
  assign at_sum    = (phase == sld_pkg::PH_SUM);

  // Hold the lingo id written over the config channel
  always_ff @(posedge clk) begin
    if (rst) begin
      match_id <= 8'd0;
    end else if (cfg.valid) begin
      match_id <= cfg.accepted_lingo_id;
    end
  end

  // Next phase and frame fields
  always_comb begin
    phase_next             = phase;
    length_value_next      = length_value;
    data_count_next        = data_count;
    running_sum_next       = running_sum;
    command_value_next     = command_value;
    transaction_value_next = transaction_value;
    case (phase)
      sld_pkg::PH_SYNC2: begin
        phase_next = (b == sld_pkg::SYNC_MARK) ? sld_pkg::PH_LEN : sld_pkg::PH_SYNC1;
      end
      sld_pkg::PH_LEN: begin
        running_sum_next = b;
        if (b == sld_pkg::LEN_EXTEND) begin
          phase_next = sld_pkg::PH_LEN_LO;
        end else begin
          length_value_next = {8'd0, b};
          phase_next        = sld_pkg::PH_ID;
        end
      end
      sld_pkg::PH_LEN_LO: begin
        running_sum_next  = sum_add;
        length_value_next = {8'd0, b};
        phase_next        = sld_pkg::PH_LEN_HI;
      end
      sld_pkg::PH_LEN_HI: begin
        running_sum_next  = sum_add;
        length_value_next = {b, length_value[7:0]};
        phase_next        = sld_pkg::PH_ID;
      end
      sld_pkg::PH_ID: begin
        running_sum_next = sum_add;
        phase_next = (b == match_id) ? sld_pkg::PH_CMD : sld_pkg::PH_SYNC1;
      end
      sld_pkg::PH_CMD: begin
        running_sum_next   = sum_add;
        command_value_next = b;
        phase_next         = sld_pkg::PH_TR_LO;
      end
      sld_pkg::PH_TR_LO: begin
        running_sum_next       = sum_add;
        transaction_value_next = {8'd0, b};
        phase_next             = sld_pkg::PH_TR_HI;
      end
      sld_pkg::PH_TR_HI: begin
        running_sum_next       = sum_add;
        transaction_value_next = {b, transaction_value[7:0]};
        data_count_next        = 16'd0;
        phase_next = (payload_len != 16'd0) ? sld_pkg::PH_DATA : sld_pkg::PH_SUM;
      end
      sld_pkg::PH_DATA: begin
        running_sum_next = sum_add;
        data_count_next  = count_inc;
        if (count_inc >= payload_len) begin
          phase_next = sld_pkg::PH_SUM;
        end
      end
      sld_pkg::PH_SUM: begin
        phase_next = sld_pkg::PH_SYNC1;
      end
      default: begin
        if (b == sld_pkg::SYNC_LEAD) begin
          phase_next = sld_pkg::PH_SYNC2;
        end else if (b == sld_pkg::SYNC_MARK) begin
          phase_next = sld_pkg::PH_LEN;
        end else begin
          phase_next = sld_pkg::PH_SYNC1;
        end
      end
    endcase
  end

  // Build the result for the current byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      sld_pkg::PH_DATA: begin
        res_valid         = take;
        res.kind          = sld_pkg::KIND_DATA;
        res.payload_byte  = b;
        res.payload_index = data_count;
      end
      sld_pkg::PH_SUM: begin
        res_valid          = take;
        res.kind           = sld_pkg::KIND_END;
        res.command_code   = command_value;
        res.transaction_id = transaction_value;
        res.frame_length   = length_value;
        res.checksum_ok    = (sum_add == 8'd0);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= sld_pkg::PH_SYNC1;
      length_value      <= 16'd0;
      data_count        <= 16'd0;
      running_sum       <= 8'd0;
      command_value     <= 8'd0;
      transaction_value <= 16'd0;
    end else if (take) begin
      phase             <= phase_next;
      length_value      <= length_value_next;
      data_count        <= data_count_next;
      running_sum       <= running_sum_next;
      command_value     <= command_value_next;
      transaction_value <= transaction_value_next;
    end
  end

  `SLD_ASSERT(a_res_phase, clk, rst, !res_valid || at_data || at_sum, "stray result")
  `SLD_ASSERT(a_count_bound, clk, rst, !at_data || data_count < payload_len, "count past payload")
  `SLD_ASSERT_NEXT(a_end_rearm, clk, rst, take && at_sum, phase == sld_pkg::PH_SYNC1, "no rearm")
  `SLD_ASSERT_NEXT(a_stall_hold, clk, rst, !take, $stable({phase, running_sum}), "moved on stall")

endmodule

`default_nettype wire

@@ src/sld_out_reg.sv @@
`default_nettype none

module sld_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire sld_pkg::res_t  din,
  output logic                up_ready,
  sld_res_if.source           res
);

  logic          valid;
  sld_pkg::res_t data;

  // Refill whenever the register is empty or being drained
  assign up_ready = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && load) begin
      data <= din;
    end
  end

  assign res.valid          = valid;
  assign res.kind           = data.kind;
  assign res.payload_byte   = data.payload_byte;
  assign res.payload_index  = data.payload_index;
  assign res.command_code   = data.command_code;
  assign res.transaction_id = data.transaction_id;
  assign res.frame_length   = data.frame_length;
  assign res.checksum_ok    = data.checksum_ok;

endmodule

`default_nettype wire

@@ src/sync_length_checksum_deframer_unit.sv @@
`default_nettype none

// Channel  Dir  Carries
// -------  ---  ----------------------------------------------------------
// rx       in   one received byte per request
// cfg      in   accepted lingo id, taken at any cycle (ready tied high)
// res      out  payload byte or frame-end summary, one per request
//
// One byte per cycle while res is not stalled; a result appears in the
// cycle after the byte that causes it, held in a single output register.
// rx is ready whenever the output register is empty or drained this cycle.
// Reset (rst, synchronous) returns to hunting for sync and clears the lingo id.
// A stall on res holds the parser state and the pending result.

module sync_length_checksum_deframer_unit (
  input  wire logic clk,
  input  wire logic rst,
  sld_rx_if.sink    rx,
  sld_cfg_if.sink   cfg,
  sld_res_if.source res
);

  logic          up_ready;
  logic          res_valid;
  sld_pkg::res_t res_data;

  // Frame parser and checksum
  sld_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .down_ready (up_ready),
    .res_valid  (res_valid),
    .res        (res_data)
  );

  // Result register toward the sink
  sld_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .din      (res_data),
    .up_ready (up_ready),
    .res      (res)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_BYTES = 240;
  localparam int PRINT_CAP = 40;

  typedef enum logic [1:0] {
    REQ_BYTE,
    REQ_LINGO,
    REQ_DRAIN
  } req_kind_t;

  typedef struct {
    req_kind_t  what;
    logic [7:0] value;
  } stim_req_t;

  logic clk = 1'b0;
  logic rst;

  sld_rx_if  rx_ch();
  sld_cfg_if cfg_ch();
  sld_res_if res_ch();

  sync_length_checksum_deframer_unit u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  // Pending requests for the driver and results the parser still owes
  stim_req_t     rx_backlog[$];
  sld_pkg::res_t owed_results[$];

  int   stim_bytes;
  int   mismatch_count;
  int   results_seen;
  int   results_owed;
  int   idle_cycles;
  logic stim_done;

  // Driver and result-side pacing
  int rx_gap;
  int rx_calm;
  int settle_count;
  int stall_left;
  int res_calm;

  // Shadow parser state
  sld_pkg::phase_t parse_phase;
  logic [15:0] frame_len;
  logic [15:0] payload_seen;
  logic [15:0] trans_hold;
  logic [7:0]  sum_acc;
  logic [7:0]  cmd_hold;
  logic [7:0]  match_id;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(0, 4));
    if (r < 65) return 16'($urandom_range(5, 16));
    if (r < 90) return 16'($urandom_range(17, 60));
    if (r < 98) return 16'($urandom_range(61, 255));
    return 16'($urandom_range(256, 700));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // Advance the shadow parser by one byte and queue any result it causes
  task automatic advance_parser(input logic [7:0] b);
    sld_pkg::res_t r;
    logic [15:0]   body;
    logic [7:0]    total;
    r = '0;
    body = (frame_len > sld_pkg::HDR_BYTES) ? frame_len - sld_pkg::HDR_BYTES : 16'd0;
    total = sum_acc + b;
    case (parse_phase)
      sld_pkg::PH_SYNC2: begin
        parse_phase = (b == sld_pkg::SYNC_MARK) ? sld_pkg::PH_LEN : sld_pkg::PH_SYNC1;
      end
      sld_pkg::PH_LEN: begin
        sum_acc = b;
        if (b == sld_pkg::LEN_EXTEND) begin
          parse_phase = sld_pkg::PH_LEN_LO;
        end else begin
          frame_len = {8'h00, b};
          parse_phase = sld_pkg::PH_ID;
        end
      end
      sld_pkg::PH_LEN_LO: begin
        sum_acc = total;
        frame_len = {8'h00, b};
        parse_phase = sld_pkg::PH_LEN_HI;
      end
      sld_pkg::PH_LEN_HI: begin
        sum_acc = total;
        frame_len[15:8] = b;
        parse_phase = sld_pkg::PH_ID;
      end
      sld_pkg::PH_ID: begin
        sum_acc = total;
        parse_phase = (b == match_id) ? sld_pkg::PH_CMD : sld_pkg::PH_SYNC1;
      end
      sld_pkg::PH_CMD: begin
        sum_acc = total;
        cmd_hold = b;
        parse_phase = sld_pkg::PH_TR_LO;
      end
      sld_pkg::PH_TR_LO: begin
        sum_acc = total;
        trans_hold = {8'h00, b};
        parse_phase = sld_pkg::PH_TR_HI;
      end
      sld_pkg::PH_TR_HI: begin
        sum_acc = total;
        trans_hold[15:8] = b;
        payload_seen = '0;
        parse_phase = (body > 16'd0) ? sld_pkg::PH_DATA : sld_pkg::PH_SUM;
      end
      sld_pkg::PH_DATA: begin
        sum_acc = total;
        r.kind = sld_pkg::KIND_DATA;
        r.payload_byte = b;
        r.payload_index = payload_seen;
        owed_results.push_back(r);
        payload_seen = payload_seen + 16'd1;
        if (payload_seen >= body) parse_phase = sld_pkg::PH_SUM;
      end
      sld_pkg::PH_SUM: begin
        r.kind = sld_pkg::KIND_END;
        r.command_code = cmd_hold;
        r.transaction_id = trans_hold;
        r.frame_length = frame_len;
        r.checksum_ok = (total == 8'h00);
        owed_results.push_back(r);
        parse_phase = sld_pkg::PH_SYNC1;
      end
      default: begin
        if (b == sld_pkg::SYNC_LEAD) parse_phase = sld_pkg::PH_SYNC2;
        else if (b == sld_pkg::SYNC_MARK) parse_phase = sld_pkg::PH_LEN;
        else parse_phase = sld_pkg::PH_SYNC1;
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_backlog.push_back('{REQ_BYTE, b});
    stim_bytes++;
  endtask

  // Build one frame; keep only the first cut bytes when cut is not negative
  task automatic queue_frame(input logic [7:0] id, input logic [15:0] len,
                             input bit long_form, input bit bare_sync, input bit bad_sum,
                             input logic [7:0] cmd, input logic [15:0] tr, input int cut);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         body;
    if (!bare_sync) bytes.push_back(sld_pkg::SYNC_LEAD);
    bytes.push_back(sld_pkg::SYNC_MARK);
    if (long_form) begin
      bytes.push_back(sld_pkg::LEN_EXTEND);
      bytes.push_back(len[7:0]);
      bytes.push_back(len[15:8]);
    end else begin
      bytes.push_back(len[7:0]);
    end
    sum = len[7:0] + len[15:8] + id + cmd + tr[7:0] + tr[15:8];
    bytes.push_back(id);
    bytes.push_back(cmd);
    bytes.push_back(tr[7:0]);
    bytes.push_back(tr[15:8]);
    body = (len > sld_pkg::HDR_BYTES) ? int'(len - sld_pkg::HDR_BYTES) : 0;
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom_range(0, 255));
      bytes.push_back(b);
      sum = sum + b;
    end
    b = 8'h00 - sum;
    if (bad_sum) b = b + 8'($urandom_range(1, 255));
    bytes.push_back(b);
    for (int i = 0; i < bytes.size() && (cut < 0 || i < cut); i++) queue_byte(bytes[i]);
  endtask

  // Random frame with the given lingo id, with an optional bad sum or cut
  task automatic queue_random_frame(input logic [7:0] id, input bit bad_sum, input int cut);
    logic [15:0] len;
    bit          long_form;
    len = pick_length();
    long_form = (len == 16'd0 || len > 16'd255) ? 1'b1 : ($urandom_range(0, 3) == 0);
    queue_frame(id, len, long_form, 1'($urandom_range(0, 1)), bad_sum,
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), cut);
  endtask

  // Drive rx and cfg requests from the backlog
  always @(posedge clk) begin
    logic       send_valid;
    logic [7:0] send_byte;
    logic       write_valid;
    logic [7:0] write_id;
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= 8'h00;
      cfg_ch.valid <= 1'b0;
      cfg_ch.accepted_lingo_id <= 8'h00;
      stim_done <= 1'b0;
      rx_gap = 0;
      rx_calm = 0;
      settle_count = 0;
    end else begin
      send_valid = rx_ch.valid && !rx_ch.ready;
      send_byte = rx_ch.rx_byte;
      write_valid = cfg_ch.valid && !cfg_ch.ready;
      write_id = cfg_ch.accepted_lingo_id;
      if (!send_valid && !write_valid) begin
        if (rx_gap > 0) begin
          rx_gap--;
        end else if (rx_backlog.size() > 0) begin
          if (rx_backlog[0].what == REQ_BYTE) begin
            send_valid = 1'b1;
            send_byte = rx_backlog[0].value;
            void'(rx_backlog.pop_front());
            if (rx_calm > 0) begin
              rx_calm--;
            end else begin
              rx_gap = pick_gap();
              if ($urandom_range(0, 63) == 0) rx_calm = $urandom_range(20, 80);
            end
          end else if (results_owed != 0) begin
            // Hold until the parser has delivered everything
            settle_count = 0;
          end else if (settle_count < SETTLE_CYCLES) begin
            settle_count++;
          end else begin
            if (rx_backlog[0].what == REQ_LINGO) begin
              write_valid = 1'b1;
              write_id = rx_backlog[0].value;
            end
            void'(rx_backlog.pop_front());
            settle_count = 0;
          end
        end
      end
      rx_ch.valid <= send_valid;
      rx_ch.rx_byte <= send_byte;
      cfg_ch.valid <= write_valid;
      cfg_ch.accepted_lingo_id <= write_id;
      stim_done <= (rx_backlog.size() == 0) && !send_valid && !write_valid;
    end
  end

  // Stall the result channel at random, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      res_calm = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (res_calm > 0) begin
      res_calm--;
      res_ch.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) res_calm = $urandom_range(20, 80);
      stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      res_ch.ready <= (stall_left == 0);
    end
  end

  // Check results, then track config writes and accepted bytes
  always @(posedge clk) begin
    sld_pkg::res_t want;
    if (rst) begin
      parse_phase = sld_pkg::PH_SYNC1;
      frame_len = '0;
      payload_seen = '0;
      trans_hold = '0;
      sum_acc = '0;
      cmd_hold = '0;
      match_id = '0;
      results_owed <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing owed", results_seen));
        end else begin
          want = owed_results.pop_front();
          check_field("kind", 16'(res_ch.kind), 16'(want.kind));
          check_field("payload_byte", 16'(res_ch.payload_byte), 16'(want.payload_byte));
          check_field("payload_index", res_ch.payload_index, want.payload_index);
          check_field("command_code", 16'(res_ch.command_code), 16'(want.command_code));
          check_field("transaction_id", res_ch.transaction_id, want.transaction_id);
          check_field("frame_length", res_ch.frame_length, want.frame_length);
          check_field("checksum_ok", 16'(res_ch.checksum_ok), 16'(want.checksum_ok));
        end
        results_seen++;
      end
      if (cfg_ch.valid && cfg_ch.ready) match_id = cfg_ch.accepted_lingo_id;
      if (rx_ch.valid && rx_ch.ready) advance_parser(rx_ch.rx_byte);
      results_owed <= owed_results.size();
    end
  end

  // End the run when no request moves for too long
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] lingo_plan[5];
    logic [7:0] id;
    int         phase_end;
    int         r;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.accepted_lingo_id = 8'h00;
    res_ch.ready = 1'b0;
    idle_cycles = 0;
    stim_bytes = 0;
    mismatch_count = 0;
    results_seen = 0;

    // Directed: short lengths, empty payloads, extremes, drops and bad sums
    rx_backlog.push_back('{REQ_LINGO, 8'h00});
    queue_frame(8'h00, 16'd1, 1'b0, 1'b1, 1'b0, 8'h00, 16'h0000, -1);
    queue_frame(8'h00, 16'd4, 1'b0, 1'b0, 1'b0, 8'h12, 16'h3456, -1);
    queue_frame(8'h00, 16'd0, 1'b1, 1'b0, 1'b0, 8'hFF, 16'hFFFF, -1);
    queue_frame(8'h00, 16'd6, 1'b1, 1'b0, 1'b1, 8'h81, 16'h00FF, -1);
    queue_frame(8'h01, 16'd5, 1'b0, 1'b1, 1'b0, 8'h22, 16'h1234, -1);
    queue_byte(sld_pkg::SYNC_LEAD);
    queue_frame(8'h00, 16'd3, 1'b0, 1'b0, 1'b0, 8'h7E, 16'hFF00, -1);
    queue_byte(sld_pkg::SYNC_LEAD);
    queue_byte(8'h00);
    queue_frame(8'h00, 16'd2, 1'b0, 1'b1, 1'b0, 8'h01, 16'h8000, -1);
    rx_backlog.push_back('{REQ_DRAIN, 8'h00});

    // Random phases, each under its own lingo id
    lingo_plan[0] = 8'hFF;
    lingo_plan[1] = 8'($urandom_range(1, 254));
    lingo_plan[2] = sld_pkg::SYNC_MARK;
    lingo_plan[3] = 8'($urandom_range(1, 254));
    lingo_plan[4] = 8'h00;
    foreach (lingo_plan[p]) begin
      id = lingo_plan[p];
      rx_backlog.push_back('{REQ_LINGO, id});
      phase_end = stim_bytes + PHASE_BYTES;
      while (stim_bytes < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          queue_random_frame(id, 1'b0, -1);
        end else if (r < 78) begin
          queue_random_frame(id, 1'b1, -1);
        end else if (r < 85) begin
          queue_random_frame(id ^ 8'($urandom_range(1, 255)), 1'b0, -1);
        end else if (r < 93) begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
              0: queue_byte(sld_pkg::SYNC_LEAD);
              1: queue_byte(sld_pkg::SYNC_MARK);
              2: queue_byte(sld_pkg::LEN_EXTEND);
              default: queue_byte(8'($urandom_range(0, 255)));
            endcase
          end
        end else if (r < 98) begin
          queue_random_frame(id, 1'b0, $urandom_range(1, 8));
        end else begin
          rx_backlog.push_back('{REQ_DRAIN, 8'h00});
        end
      end
    end
    queue_random_frame(8'h00, 1'b0, -1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the backlog to drain and every result to arrive
    do @(posedge clk); while (!(stim_done && results_owed == 0));
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (owed_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
